/* sv/ptle_pkg.sv */
// Package for the priority task list engine.
// Holds the shared types and codes; no dependencies.
package ptle_pkg;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_ADD    = 3'd1,
		OP_DELETE = 3'd2,
		OP_STEP   = 3'd3,
		OP_SETTAG = 3'd4,
		OP_READ   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_PASS_END = 2'd2,
		ST_BAD_SLOT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_DECODE,
		S_ADD_WR,
		S_ADD_WALK,
		S_LINK1,
		S_LINK2,
		S_DEL_CHK,
		S_DEL_WIPE,
		S_STEP_RD,
		S_ACC,
		S_EMIT
	} state_t;

	// One input word as the core sees it.
	typedef struct packed {
		op_t         op;
		logic [15:0] pri;
		logic [31:0] tag;
		logic        has_handler;
		logic [5:0]  slot;
	} req_t;

	// One result word.
	typedef struct packed {
		status_t     status;
		logic [5:0]  slot;
		logic [15:0] pri;
		logic [31:0] tag;
		logic        run_now;
	} res_t;

	// Per-slot record held in the data memory.
	typedef struct packed {
		logic [15:0] pri;
		logic [31:0] tag;
		logic        has_handler;
		logic        deferred;
		logic        live;
	} rec_t;

	localparam logic DEFER_CLEAR = 1'b0;
	localparam logic DEFER_SET   = 1'b1;

endpackage

/* sv/ptle_ram.sv */
// Simple dual-port memory: one write port, one read port with registered data.
// No dependencies.
module ptle_ram #(
	parameter int unsigned W = 8,
	parameter int unsigned D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/ptle_core.sv */
// Sequencer of the priority task list engine: list links, free stack and records.
// Depends on ptle_pkg and ptle_ram.
module ptle_core #(
	parameter int unsigned POOL_SLOTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [6:0]    slot_count,
	input  logic          req_valid,
	output logic          req_ready,
	input  ptle_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output ptle_pkg::res_t res
);
	import ptle_pkg::*;

	localparam int unsigned SW = $clog2(POOL_SLOTS);
	localparam int unsigned NW = $clog2(POOL_SLOTS + 1);
	localparam int unsigned RW = $bits(rec_t);
	localparam logic [NW-1:0] HEAD = NW'(POOL_SLOTS);
	localparam logic [8:0] POOL9 = 9'(POOL_SLOTS);
	localparam logic [6:0] RST_COUNT = 7'((POOL_SLOTS < 64) ? POOL_SLOTS : 64);

	function automatic logic [NW-1:0] clamp_cnt(input logic [6:0] c);
		logic [NW-1:0] r;
		if (c == 7'd0) begin
			r = NW'(1);
		end else if ({2'b00, c} > POOL9) begin
			r = HEAD;
		end else begin
			r = NW'(c);
		end
		return r;
	endfunction

	state_t state_q, state_d;
	req_t req_q;
	res_t res_q;
	logic [NW-1:0] active_q, free_top_q, head_first_q, head_last_q;
	logic [NW-1:0] cur_now_q, cur_next_q, find_q, lp_q, ln_q;
	logic [SW-1:0] new_s_q, cnt_q;
	logic in_pass_q, sweep_emit_q;

	// Memory ports
	logic [SW-1:0] rd_addr, fs_raddr;
	logic next_we, prev_we, data_we, fs_we;
	logic [SW-1:0] next_wa, prev_wa, data_wa, fs_wa;
	logic [NW-1:0] next_wd, prev_wd, next_rd, prev_rd;
	rec_t data_wd, data_rd;
	logic [RW-1:0] data_rd_raw;
	logic [SW-1:0] fs_wd, fs_rd;

	ptle_ram #(.W(NW), .D(POOL_SLOTS)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(rd_addr), .rdata(next_rd));
	ptle_ram #(.W(NW), .D(POOL_SLOTS)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(rd_addr), .rdata(prev_rd));
	ptle_ram #(.W(RW), .D(POOL_SLOTS)) u_data (
		.clk(clk), .we(data_we), .waddr(data_wa), .wdata(data_wd),
		.raddr(rd_addr), .rdata(data_rd_raw));
	ptle_ram #(.W(SW), .D(POOL_SLOTS)) u_free (
		.clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
		.raddr(fs_raddr), .rdata(fs_rd));

	assign data_rd = rec_t'(data_rd_raw);

	// The shared priority compare serves both the deferral test and the walk.
	logic cmp_le;
	assign cmp_le = data_rd.pri <= req_q.pri;

	logic [SW-1:0] slot_idx;
	logic slot_rng, slot_good, pass_end, cur_is_new, defer_new;
	logic [NW-1:0] step_node;
	assign slot_idx = SW'(req_q.slot);
	assign slot_rng = {3'b000, req_q.slot} < 9'(active_q);
	assign slot_good = slot_rng && data_rd.live;
	assign step_node = in_pass_q ? cur_next_q : head_first_q;
	assign pass_end = step_node == HEAD;
	assign cur_is_new = cur_now_q == NW'(fs_rd);
	assign defer_new = cur_is_new ? req_q.has_handler :
		((cur_now_q != HEAD) && data_rd.has_handler && cmp_le);

	assign req_ready = state_q == S_IDLE;
	assign res_valid = state_q == S_EMIT;
	assign res = res_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP: begin
				if (cnt_q == SW'(POOL_SLOTS - 1)) begin
					state_d = sweep_emit_q ? S_EMIT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (req_q.op) inside
					OP_CLEAR:  state_d = S_SWEEP;
					OP_ADD:    state_d = (free_top_q >= active_q) ? S_EMIT : S_ADD_WR;
					OP_DELETE: state_d = S_DEL_CHK;
					OP_STEP:   state_d = pass_end ? S_EMIT : S_STEP_RD;
					OP_SETTAG, OP_READ: state_d = S_ACC;
					default:   state_d = S_EMIT;
				endcase
			end
			S_ADD_WR:   state_d = S_ADD_WALK;
			S_ADD_WALK: begin
				if (find_q == HEAD || !cmp_le) begin
					state_d = S_LINK1;
				end
			end
			S_LINK1:    state_d = S_LINK2;
			S_LINK2:    state_d = S_EMIT;
			S_DEL_CHK:  state_d = slot_good ? S_DEL_WIPE : S_EMIT;
			S_DEL_WIPE: state_d = S_EMIT;
			S_STEP_RD:  state_d = S_EMIT;
			S_ACC:      state_d = S_EMIT;
			S_EMIT: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		rd_addr = slot_idx;
		fs_raddr = free_top_q[SW-1:0];
		next_we = 1'b0; next_wa = new_s_q; next_wd = HEAD;
		prev_we = 1'b0; prev_wa = new_s_q; prev_wd = HEAD;
		data_we = 1'b0; data_wa = slot_idx; data_wd = '0;
		fs_we = 1'b0; fs_wa = cnt_q; fs_wd = cnt_q;
		unique case (state_q)
			S_SWEEP: begin
				next_we = 1'b1; next_wa = cnt_q;
				prev_we = 1'b1; prev_wa = cnt_q;
				data_we = 1'b1; data_wa = cnt_q;
				fs_we = 1'b1;
			end
			S_DECODE: begin
				if (req_q.op == OP_ADD) begin
					rd_addr = cur_now_q[SW-1:0];
				end else if (req_q.op == OP_STEP) begin
					rd_addr = step_node[SW-1:0];
				end
			end
			S_ADD_WR: begin
				data_we = 1'b1;
				data_wa = fs_rd;
				data_wd = '{pri: req_q.pri, tag: req_q.tag, has_handler: req_q.has_handler,
					deferred: defer_new ? DEFER_SET : DEFER_CLEAR, live: 1'b1};
				rd_addr = head_first_q[SW-1:0];
			end
			S_ADD_WALK: begin
				rd_addr = next_rd[SW-1:0];
			end
			S_LINK1: begin
				next_we = 1'b1; next_wd = ln_q;
				prev_we = 1'b1; prev_wd = lp_q;
			end
			S_LINK2: begin
				next_we = lp_q != HEAD; next_wa = lp_q[SW-1:0]; next_wd = NW'(new_s_q);
				prev_we = ln_q != HEAD; prev_wa = ln_q[SW-1:0]; prev_wd = NW'(new_s_q);
			end
			S_DEL_CHK: begin
				next_we = slot_good && prev_rd != HEAD;
				next_wa = prev_rd[SW-1:0]; next_wd = next_rd;
				prev_we = slot_good && next_rd != HEAD;
				prev_wa = next_rd[SW-1:0]; prev_wd = prev_rd;
			end
			S_DEL_WIPE: begin
				next_we = 1'b1; next_wa = slot_idx;
				prev_we = 1'b1; prev_wa = slot_idx;
				data_we = 1'b1;
				fs_we = free_top_q != '0;
				fs_wa = SW'(free_top_q - NW'(1));
				fs_wd = slot_idx;
			end
			S_STEP_RD: begin
				data_we = data_rd.deferred != DEFER_CLEAR;
				data_wa = cur_now_q[SW-1:0];
				data_wd = data_rd;
				data_wd.deferred = DEFER_CLEAR;
			end
			S_ACC: begin
				data_we = slot_good && req_q.op == OP_SETTAG;
				data_wd = data_rd;
				data_wd.tag = req_q.tag;
				data_wd.has_handler = req_q.has_handler;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			active_q <= clamp_cnt(RST_COUNT);
			free_top_q <= '0;
			head_first_q <= HEAD;
			head_last_q <= HEAD;
			cur_now_q <= HEAD;
			cur_next_q <= HEAD;
			in_pass_q <= 1'b0;
			cnt_q <= '0;
			sweep_emit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_SWEEP: begin
					if (cnt_q == SW'(POOL_SLOTS - 1)) begin
						cnt_q <= '0;
						free_top_q <= '0;
						head_first_q <= HEAD;
						head_last_q <= HEAD;
						cur_now_q <= HEAD;
						cur_next_q <= HEAD;
						in_pass_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q + SW'(1);
					end
				end
				S_DECODE: begin
					if (req_q.op == OP_CLEAR) begin
						active_q <= clamp_cnt(slot_count);
						cnt_q <= '0;
						sweep_emit_q <= 1'b1;
					end else if (req_q.op == OP_STEP) begin
						if (pass_end) begin
							cur_now_q <= HEAD;
							in_pass_q <= 1'b0;
						end else begin
							cur_now_q <= step_node;
							in_pass_q <= 1'b1;
						end
					end
				end
				S_ADD_WR: begin
					new_s_q <= fs_rd;
					free_top_q <= free_top_q + NW'(1);
					find_q <= head_first_q;
				end
				S_ADD_WALK: begin
					if (find_q == HEAD) begin
						lp_q <= head_last_q;
						ln_q <= HEAD;
					end else if (!cmp_le) begin
						lp_q <= prev_rd;
						ln_q <= find_q;
					end else begin
						find_q <= next_rd;
					end
				end
				S_LINK1: begin
					if (cur_next_q == ln_q) begin
						cur_next_q <= NW'(new_s_q);
					end
				end
				S_LINK2: begin
					if (lp_q == HEAD) begin
						head_first_q <= NW'(new_s_q);
					end
					if (ln_q == HEAD) begin
						head_last_q <= NW'(new_s_q);
					end
				end
				S_DEL_CHK: begin
					if (slot_good) begin
						if (cur_next_q == NW'(slot_idx)) begin
							cur_next_q <= next_rd;
						end
						if (prev_rd == HEAD) begin
							head_first_q <= next_rd;
						end
						if (next_rd == HEAD) begin
							head_last_q <= prev_rd;
						end
					end
				end
				S_DEL_WIPE: begin
					if (free_top_q != '0) begin
						free_top_q <= free_top_q - NW'(1);
					end
				end
				S_STEP_RD: begin
					cur_next_q <= next_rd;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		case (state_q)
			S_DECODE: begin
				if (req_q.op == OP_ADD) begin
					res_q <= '{status: ST_NO_FREE, slot: '0, pri: '0, tag: '0,
						run_now: 1'b0};
				end else if (req_q.op == OP_STEP) begin
					res_q <= '{status: ST_PASS_END, slot: '0, pri: '0, tag: '0,
						run_now: 1'b0};
				end else begin
					res_q <= '0;
				end
			end
			S_LINK2: begin
				res_q.status <= ST_OK;
				res_q.slot <= 6'(new_s_q);
				res_q.pri <= req_q.pri;
				res_q.tag <= req_q.tag;
			end
			S_DEL_CHK: begin
				res_q.status <= slot_good ? ST_OK : ST_BAD_SLOT;
				res_q.slot <= req_q.slot;
			end
			S_STEP_RD: begin
				res_q.status <= ST_OK;
				res_q.slot <= 6'(cur_now_q);
				res_q.pri <= data_rd.pri;
				res_q.tag <= data_rd.tag;
				res_q.run_now <= (data_rd.deferred == DEFER_CLEAR) && data_rd.has_handler;
			end
			S_ACC: begin
				res_q.slot <= req_q.slot;
				if (slot_good) begin
					res_q.status <= ST_OK;
					res_q.pri <= data_rd.pri;
					res_q.tag <= (req_q.op == OP_SETTAG) ? req_q.tag : data_rd.tag;
				end else begin
					res_q.status <= ST_BAD_SLOT;
				end
			end
			default: begin
			end
		endcase
	end

	a_free_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SWEEP) |-> (free_top_q <= active_q))
		else $error("free stack pointer beyond active slots");
	a_head_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((head_first_q == HEAD) == (head_last_q == HEAD)))
		else $error("list head ends disagree on emptiness");
	a_cursor_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_pass_q |-> cur_now_q == HEAD) else $error("cursor off head outside a pass");
	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q != '0 && active_q <= HEAD) else $error("active slot count out of range");
endmodule

/* sv/priority_task_list_engine.sv */
// Top level of the priority task list engine: stream ports, configuration
// register and result register. Depends on ptle_pkg and ptle_core.
//
// Usage. Commands arrive as words on the slave stream (s_*): s_tuser carries
// the opcode and s_tdata the operands. Every command yields exactly one word
// on the master stream (m_*): m_tuser carries the status, m_tdata the slot,
// priority, tag and run flag. The slot_count register is written through
// cfg_we/cfg_wdata and takes effect at the next clear; the user must write it
// only while the engine is idle, and the block itself leaves this unchecked.
// An unused opcode, an add to a full pool and a step that ends the pass go
// from decode straight to the result. An add walks the list from its first
// entry to the insertion point, or off the tail when no entry has a higher
// priority. A clear sweeps every slot, one per cycle. After reset the same
// sweep runs with s_tready low; no result word is produced for it.
// A finished result waits in the output register while the next command is
// already accepted; if m_tready stays low the engine holds the new result
// internally and takes no further command until the output word is taken.
module priority_task_list_engine #(
	parameter int unsigned POOL_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// priority_req[15:0], tag[47:16], has_handler[48], slot[54:49], zero pad
	input  logic [55:0] s_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// slot_out[5:0], priority_out[21:6], tag_out[53:22], run_now[54], zero pad
	output logic [55:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser
);
	import ptle_pkg::*;

	// Reset value of the slot count register follows the pool size.
	localparam logic [6:0] RST_COUNT = 7'((POOL_SLOTS < 64) ? POOL_SLOTS : 64);

	logic [6:0] slot_count_q;
	logic m_tvalid_q;
	logic [55:0] m_tdata_q;
	logic [1:0] m_tuser_q;
	req_t req;
	res_t res;
	logic res_valid, res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= RST_COUNT;
		end else if (cfg_we) begin
			slot_count_q <= cfg_wdata;
		end
	end

	// Unpack the command word into the core's request.
	assign req = '{op: op_t'(s_tuser), pri: s_tdata[15:0], tag: s_tdata[47:16],
		has_handler: s_tdata[48], slot: s_tdata[54:49]};

	ptle_core #(.POOL_SLOTS(POOL_SLOTS)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.slot_count(slot_count_q),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// The output register is free when empty or being drained this cycle.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {1'b0, res.run_now, res.tag, res.pri, res.slot};
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
endmodule

/* test/tb_top.sv */
// Self-checking testbench for priority_task_list_engine.
// Depends on ptle_pkg and the engine RTL. A built-in list model predicts every result word.
`timescale 1ns / 1ps

module tb_top;
	import ptle_pkg::*;

	localparam int unsigned SLOTS = 64;
	localparam logic [6:0] HEAD = 7'd64;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	typedef struct {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [15:0] pri;
		logic [31:0] tag;
		logic        run_now;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;

	priority_task_list_engine #(.POOL_SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// List model state: links, per-slot records, free stack and pass cursor.
	logic [6:0]  nxt [SLOTS];
	logic [6:0]  prv [SLOTS];
	logic [6:0]  first_ent, last_ent;
	logic [15:0] rec_pri [SLOTS];
	logic [31:0] rec_tag [SLOTS];
	logic        rec_hh [SLOTS];
	logic        rec_def [SLOTS];
	logic        rec_live [SLOTS];
	logic [5:0]  free_stk [SLOTS];
	int unsigned free_top;
	logic [6:0]  cur_now, cur_next;
	logic        passing;
	logic [6:0]  slot_count_reg = 7'd64;
	int unsigned active_slots;

	outcome_t    pending[$];
	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned words_checked = 0;
	int unsigned passes_ended = 0;
	bit          tx_no_gap = 1'b0;
	bit          rx_no_stall = 1'b0;
	bit          rx_hold = 1'b0;

	function automatic void set_link_next(logic [6:0] n, logic [6:0] v);
		if (n < HEAD) nxt[n] = v; else first_ent = v;
	endfunction

	function automatic void set_link_prev(logic [6:0] n, logic [6:0] v);
		if (n < HEAD) prv[n] = v; else last_ent = v;
	endfunction

	function automatic void wipe(int s);
		nxt[s] = HEAD; prv[s] = HEAD;
		rec_pri[s] = '0; rec_tag[s] = '0;
		rec_hh[s] = 1'b0; rec_def[s] = 1'b0; rec_live[s] = 1'b0;
	endfunction

	function automatic void list_clear();
		active_slots = (slot_count_reg < 1) ? 1 : (slot_count_reg > SLOTS) ? SLOTS : slot_count_reg;
		for (int i = 0; i < SLOTS; i++) begin
			wipe(i);
			free_stk[i] = i[5:0];
		end
		free_top = 0;
		first_ent = HEAD; last_ent = HEAD;
		cur_now = HEAD; cur_next = HEAD;
		passing = 1'b0;
	endfunction

	function automatic bit slot_valid(logic [5:0] s);
		return (s < active_slots) && rec_live[s];
	endfunction

	// Works out the result word of one command and updates the list model.
	function automatic outcome_t predict_command(logic [2:0] op, logic [15:0] pri,
			logic [31:0] tag, logic hh, logic [5:0] s);
		outcome_t r;
		logic [6:0] find, p, ns;
		bit placed;
		r = '{default: '0};
		case (op)
			OP_CLEAR: list_clear();
			OP_ADD: begin
				if (free_top >= active_slots) begin
					r.status = ST_NO_FREE;
				end else begin
					ns = free_stk[free_top];
					free_top++;
					rec_pri[ns] = pri; rec_tag[ns] = tag; rec_hh[ns] = hh;
					rec_live[ns] = 1'b1;
					rec_def[ns] = DEFER_CLEAR;
					// A task added behind the current one, while that one has a handler, waits for the next pass.
					if (cur_now < HEAD && rec_hh[cur_now] && rec_pri[cur_now] <= pri)
						rec_def[ns] = DEFER_SET;
					r.slot = ns[5:0]; r.pri = pri; r.tag = tag;
					find = first_ent;
					placed = 0;
					for (int k = 0; k < SLOTS && find < HEAD && !placed; k++) begin
						if (rec_pri[find] > pri) begin
							p = prv[find];
							prv[ns] = p; nxt[ns] = find;
							set_link_next(p, ns);
							prv[find] = ns;
							if (find == cur_next) cur_next = ns;
							placed = 1;
						end else begin
							find = nxt[find];
						end
					end
					if (!placed) begin
						if (cur_next == HEAD) cur_next = ns;
						prv[ns] = last_ent; nxt[ns] = HEAD;
						set_link_next(last_ent, ns);
						last_ent = ns;
					end
				end
			end
			OP_DELETE: begin
				r.slot = s;
				if (!slot_valid(s)) begin
					r.status = ST_BAD_SLOT;
				end else begin
					if (cur_next == {1'b0, s}) cur_next = nxt[s];
					set_link_next(prv[s], nxt[s]);
					set_link_prev(nxt[s], prv[s]);
					wipe(s);
					if (free_top > 0) begin
						free_top--;
						free_stk[free_top] = s;
					end
				end
			end
			OP_STEP: begin
				cur_now = passing ? cur_next : first_ent;
				if (cur_now >= HEAD) begin
					cur_now = HEAD;
					passing = 1'b0;
					r.status = ST_PASS_END;
				end else begin
					passing = 1'b1;
					cur_next = nxt[cur_now];
					r.slot = cur_now[5:0]; r.pri = rec_pri[cur_now]; r.tag = rec_tag[cur_now];
					if (rec_def[cur_now] == DEFER_CLEAR) begin
						r.run_now = rec_hh[cur_now];
					end else begin
						rec_def[cur_now] = DEFER_CLEAR;
					end
				end
			end
			OP_SETTAG, OP_READ: begin
				r.slot = s;
				if (!slot_valid(s)) begin
					r.status = ST_BAD_SLOT;
				end else begin
					if (op == OP_SETTAG) begin
						rec_tag[s] = tag;
						rec_hh[s] = hh;
					end
					r.pri = rec_pri[s]; r.tag = rec_tag[s];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Offers one command word; the model is updated at the edge where it is taken.
	task automatic send_command(logic [2:0] op, logic [15:0] pri = '0, logic [31:0] tag = '0,
			logic hh = 1'b0, logic [5:0] s = '0);
		int unsigned gap;
		outcome_t r;
		gap = tx_no_gap ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, s, hh, tag, pri};
		do @(posedge clk); while (!s_tready);
		r = predict_command(op, pri, tag, hh, s);
		pending.push_back(r);
		words_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SLOTS + 16) @(posedge clk);
	endtask

	task automatic write_slot_count(logic [6:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		slot_count_reg = v;
	endtask

	// Picks a live slot most of the time so that deletes and reads find something.
	function automatic logic [5:0] pick_slot();
		logic [5:0] live_list[$];
		for (int i = 0; i < SLOTS; i++)
			if (rec_live[i]) live_list.push_back(i[5:0]);
		if (live_list.size() == 0 || $urandom_range(0, 9) < 2) return $urandom_range(0, 63);
		return live_list[$urandom_range(0, live_list.size() - 1)];
	endfunction

	function automatic logic [15:0] pick_priority();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3);
			1: return 16'hffff - $urandom_range(0, 1);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// Receiver: a fresh stall length is drawn after every word taken.
	int unsigned rx_wait = 0;
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			rx_wait = rx_no_stall ? 0 : $urandom_range(0, 15);
		if (rx_hold) begin
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result checker: each word taken is compared with the oldest prediction.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result word status=%0d data=%h", m_tuser, m_tdata);
			end else begin
				e = pending.pop_front();
				words_checked++;
				if (e.status == ST_PASS_END) passes_ended++;
				if (m_tuser !== e.status || m_tdata[5:0] !== e.slot || m_tdata[21:6] !== e.pri
						|| m_tdata[53:22] !== e.tag || m_tdata[54] !== e.run_now
						|| m_tdata[55] !== 1'b0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: word %0d expected st=%0d slot=%0d pri=%h tag=%h run=%0b",
							words_checked, e.status, e.slot, e.pri, e.tag, e.run_now);
						$display("       got st=%0d slot=%0d pri=%h tag=%h run=%0b",
							m_tuser, m_tdata[5:0], m_tdata[21:6], m_tdata[53:22], m_tdata[54]);
					end
				end
			end
		end
	end

	task automatic test_directed();
		send_command(OP_READ, 16'h0, 32'h0, 1'b0, 6'd0);
		send_command(OP_STEP);
		send_command(OP_ADD, 16'hffff, 32'hffffffff, 1'b1);
		send_command(OP_ADD, 16'h0000, 32'h00000000, 1'b1);
		send_command(OP_ADD, 16'h0000, 32'h5a5a5a5a, 1'b0);
		send_command(OP_ADD, 16'h8000, 32'ha5a5a5a5, 1'b1);
		// Adding during a pass while a handler task is current defers the new one.
		send_command(OP_STEP);
		send_command(OP_ADD, 16'h0001, 32'h12345678, 1'b1);
		send_command(OP_STEP);
		// Deleting a task that the pass has already stepped past leaves the cursor as it was.
		send_command(OP_DELETE, 16'h0, 32'h0, 1'b0, 6'd1);
		send_command(OP_STEP);
		send_command(OP_STEP);
		send_command(OP_STEP);
		send_command(OP_STEP);
		send_command(OP_SETTAG, 16'h0, 32'hdeadbeef, 1'b1, 6'd2);
		send_command(OP_SETTAG, 16'h0, 32'h0, 1'b0, 6'd3);
		send_command(OP_READ, 16'h0, 32'h0, 1'b0, 6'd3);
		send_command(OP_DELETE, 16'h0, 32'h0, 1'b0, 6'd63);
		send_command(OP_READ, 16'h0, 32'h0, 1'b0, 6'd1);
		send_command(OP_SPARE6, 16'hffff, 32'hffffffff, 1'b1, 6'd63);
		send_command(OP_SPARE7);
		send_command(OP_CLEAR);
	endtask

	// Small pools: a zero count acts as one, so the second add finds no free slot.
	task automatic test_small_pool();
		write_slot_count(7'd0);
		send_command(OP_CLEAR);
		send_command(OP_ADD, 16'h0010, 32'h1, 1'b1);
		send_command(OP_ADD, 16'h0010, 32'h2, 1'b1);
		send_command(OP_SETTAG, 16'h0, 32'h3, 1'b0, 6'd1);
		send_command(OP_DELETE, 16'h0, 32'h0, 1'b0, 6'd0);
		write_slot_count(7'd127);
		send_command(OP_CLEAR);
	endtask

	task automatic test_random(int unsigned count);
		int unsigned w;
		logic [2:0] op;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 100 == 50) begin
				tx_no_gap = 1'b1;
				rx_no_stall = 1'b1;
			end else if (i % 100 == 80) begin
				tx_no_gap = 1'b0;
				rx_no_stall = 1'b0;
			end
			if (i == count / 2) begin
				write_slot_count($urandom_range(2, 20));
				send_command(OP_CLEAR);
			end
			w = $urandom_range(0, 99);
			if (w < 36) op = OP_ADD;
			else if (w < 54) op = OP_DELETE;
			else if (w < 80) op = OP_STEP;
			else if (w < 88) op = OP_SETTAG;
			else if (w < 96) op = OP_READ;
			else if (w < 98) op = OP_CLEAR;
			else op = w[0] ? OP_SPARE7 : OP_SPARE6;
			send_command(op, pick_priority(), $urandom(), $urandom_range(0, 1), pick_slot());
		end
		tx_no_gap = 1'b0;
		rx_no_stall = 1'b0;
	endtask

	// The receiver holds off while words keep coming, then the sender waits it out.
	task automatic test_backpressure();
		write_slot_count(7'd64);
		send_command(OP_CLEAR);
		fork
			begin
				rx_hold = 1'b1;
				repeat (300) @(posedge clk);
				rx_hold = 1'b0;
			end
			begin
				tx_no_gap = 1'b1;
				for (int i = 0; i < 12; i++)
					send_command(i[0] ? OP_STEP : OP_ADD, pick_priority(), $urandom, 1'b1);
				tx_no_gap = 1'b0;
			end
		join
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		list_clear();
		test_directed();
		test_small_pool();
		test_random(480);
		test_backpressure();
		drain();
		$display("Checked %0d of %0d command words over several pool sizes, %0d passes ended.",
			words_checked, words_sent, passes_ended);
		if (mismatches == 0 && pending.size() == 0)
			$display("priority_task_list_engine verification clean");
		else
			$display("priority_task_list_engine verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("priority_task_list_engine verification failed");
		$finish;
	end

endmodule
